### rtl/slr_pkg.sv
package slr_pkg;

  // Generator word and multiplier widths.
  localparam int VAL_W  = 31;
  localparam int MULT_W = 15;
  localparam int PROD_W = VAL_W + MULT_W;

  // Minimal-standard Lehmer constants.
  localparam logic [MULT_W-1:0] LEHMER_MULT = 15'd16807;
  localparam logic [VAL_W-1:0]  LEHMER_MOD  = 31'h7FFF_FFFF;

  // Steps run before the table starts to take values during a reseed.
  localparam int WARMUP_EXTRA = 8;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED_MUL,
    ST_SEED_RED,
    ST_SEED_IDX,
    ST_DRAW_MUL,
    ST_DRAW_RES
  } slr_state_t;

endpackage

### rtl/slr_lehmer_unit.sv
module slr_lehmer_unit (
  input  logic                     clk,
  input  logic                     en,
  input  logic [slr_pkg::VAL_W-1:0] x,
  output logic [slr_pkg::VAL_W-1:0] y
);
  import slr_pkg::*;

  logic [PROD_W-1:0] prod;
  logic [VAL_W:0]    fold;

  // Multiply by the constant and register the product.
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= PROD_W'(x) * PROD_W'(LEHMER_MULT);
    end
  end

  // Then fold the product's high part back in, since 2^31 is 1 modulo 2^31-1.
  // The folded sum stays below twice the modulus, so one subtract finishes it.
  assign fold = (VAL_W + 1)'(prod[VAL_W-1:0]) + (VAL_W + 1)'(prod[PROD_W-1:VAL_W]);

  always_comb begin
    if (fold >= (VAL_W + 1)'(LEHMER_MOD)) begin
      y = VAL_W'(fold - (VAL_W + 1)'(LEHMER_MOD));
    end else begin
      y = VAL_W'(fold);
    end
  end

endmodule

### rtl/shuffled_lehmer_random_top.sv
// Shuffled minimal-standard random generator: a Lehmer generator
// (x = 16807 * x mod 2^31-1) feeds a table of TABLE_ENTRIES values held in an
// on-chip memory, and each beat on the input draws one shuffled value between
// 1 and 2^31-2 on the output. Divide a draw by 2^31-1 for a uniform fraction.
// An input beat with reseed set, or the first beat after reset, reloads the
// generator from the seed register (0 and 2^31-1 are taken as 1), runs
// TABLE_ENTRIES + 8 warm-up steps and refills the table before drawing.
// A normal draw runs through the shared multiply-and-fold unit that advances
// the generator, then waits until the output register is free; a new beat
// is taken only once the previous draw has gone to the output register. A
// reseeding draw first steps the generator through that same unit for each
// warm-up step. The seed register may be written only while no draw is in
// progress.
module shuffled_lehmer_random_top #(
  parameter int TABLE_ENTRIES = 32
) (
  input  logic        clk,
  input  logic        rst,
  // Seed register write port.
  input  logic        cfg_wr_en,
  input  logic [30:0] cfg_wr_data,
  // Input stream; tdata bit 0: reseed, bits 7:1: zero.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  // Output stream; tdata bits 30:0: draw, bit 31: zero.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata
);
  import slr_pkg::*;

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int PW    = VAL_W + IDX_W;
  localparam int THR_W = IDX_W + 8;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + WARMUP_EXTRA + 1);

  slr_state_t state, state_next;

  logic [VAL_W-1:0] seed_value;
  logic [VAL_W-1:0] seed_fixed;
  logic             seeded;
  logic [VAL_W-1:0] lehmer;
  logic [VAL_W-1:0] lehmer_step;
  logic [CNT_W-1:0] cnt;
  logic [PW-1:0]    last_prod;
  logic [IDX_W-1:0] rd_idx;
  logic [VAL_W-1:0] rd_data;
  logic [VAL_W-1:0] tbl [TABLE_ENTRIES];
  logic             out_valid;
  logic [VAL_W-1:0] out_data;

  logic             in_fire;
  logic             need_seed;
  logic             out_free;
  logic             mul_en;
  logic             rd_en;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic             draw_done;

  logic [IDX_W-1:0] idx_est;
  logic [VAL_W-1:0] idx_rem;
  logic [THR_W-1:0] idx_thr;
  logic [IDX_W-1:0] idx_calc;

  assign in_fire   = s_axis_tvalid & s_axis_tready;
  assign need_seed = s_axis_tdata[0] | ~seeded;
  assign out_free  = ~out_valid | m_axis_tready;

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {1'b0, out_data};

  // A seed of zero or of the modulus would lock the generator, so use 1.
  assign seed_fixed = (seed_value == '0 || seed_value == LEHMER_MOD) ? VAL_W'(1) : seed_value;

  // Shuffle index floor(T * last / (2^31 - 2 + T)). Dividing by 2^31 instead
  // gives the index or one more; the remainder test removes the excess.
  assign idx_est  = last_prod[PW-1:VAL_W];
  assign idx_rem  = last_prod[VAL_W-1:0];
  assign idx_thr  = THR_W'(idx_est) * THR_W'(TABLE_ENTRIES - 2);
  assign idx_calc = idx_est - IDX_W'(idx_rem < VAL_W'(idx_thr));

  slr_lehmer_unit u_lehmer (
    .clk (clk),
    .en  (mul_en),
    .x   (lehmer),
    .y   (lehmer_step)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          state_next = need_seed ? ST_SEED_MUL : ST_DRAW_RES;
        end
      end
      ST_SEED_MUL: state_next = ST_SEED_RED;
      ST_SEED_RED: begin
        state_next = (cnt == CNT_W'(1)) ? ST_SEED_IDX : ST_SEED_MUL;
      end
      ST_SEED_IDX: state_next = ST_DRAW_MUL;
      ST_DRAW_MUL: state_next = ST_DRAW_RES;
      ST_DRAW_RES: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    mul_en    = 1'b0;
    rd_en     = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = rd_idx;
    draw_done = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_fire && !need_seed) begin
          mul_en = 1'b1;
          rd_en  = 1'b1;
        end
      end
      ST_SEED_MUL: mul_en = 1'b1;
      ST_SEED_RED: begin
        // The last TABLE_ENTRIES warm-up values fill the table from the top.
        wr_en   = (cnt <= CNT_W'(TABLE_ENTRIES));
        wr_addr = IDX_W'(cnt - CNT_W'(1));
      end
      ST_SEED_IDX: begin
      end
      ST_DRAW_MUL: begin
        mul_en = 1'b1;
        rd_en  = 1'b1;
      end
      ST_DRAW_RES: begin
        if (out_free) begin
          wr_en     = 1'b1;
          draw_done = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Seed register and seeded flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      seed_value <= VAL_W'(1);
      seeded     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        seed_value <= cfg_wr_data;
      end
      if (state == ST_SEED_IDX) begin
        seeded <= 1'b1;
      end
    end
  end

  // Generator value, warm-up counter and index source.
  always_ff @(posedge clk) begin
    if (in_fire && need_seed) begin
      lehmer <= seed_fixed;
      cnt    <= CNT_W'(TABLE_ENTRIES + WARMUP_EXTRA);
    end
    if (state == ST_SEED_RED) begin
      lehmer <= lehmer_step;
      cnt    <= cnt - CNT_W'(1);
    end
    if (draw_done) begin
      lehmer <= lehmer_step;
    end
    // After warm-up the last value is the one in entry 0.
    if (state == ST_SEED_IDX) begin
      last_prod <= PW'(lehmer) * PW'(TABLE_ENTRIES);
    end else if (draw_done) begin
      last_prod <= PW'(rd_data) * PW'(TABLE_ENTRIES);
    end
    if (rd_en) begin
      rd_idx <= idx_calc;
    end
  end

  // Shuffle table memory. No write shares a cycle with a read, and every write
  // lands before the next read of the same entry, so no forwarding is needed.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      tbl[wr_addr] <= lehmer_step;
    end
    if (rd_en) begin
      rd_data <= tbl[idx_calc];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (draw_done) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (draw_done) begin
      out_data <= rd_data;
    end
  end

endmodule

### dv/tb_shuffled_lehmer_random_top.sv
module tb_shuffled_lehmer_random_top;
  timeunit 1ns;
  timeprecision 1ps;

  import slr_pkg::*;

  localparam int TBL = 32;
  localparam int CLK_PERIOD = 8;
  localparam int RESET_CYCLES = 6;
  localparam int ITEMS_PER_PHASE = 483;
  localparam int RESEED_CYCLES = 2 * (TBL + WARMUP_EXTRA) + 4;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int NUM_DIRECTED = 20;

  // Seeds of interest: both ends of the legal range and the two values that
  // would lock the generator at zero.
  localparam logic [VAL_W-1:0] SEED_ZERO = 31'd0;
  localparam logic [VAL_W-1:0] SEED_ONE = 31'd1;
  localparam logic [VAL_W-1:0] SEED_MAX = 31'd2147483646;
  localparam logic [VAL_W-1:0] SEED_LOCK = 31'h7FFF_FFFF;

  typedef struct packed {
    logic             wr_seed;
    logic [VAL_W-1:0] seed;
    logic             reseed;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_wr_en;
  logic [30:0] cfg_wr_data;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [7:0] s_axis_tdata;   // bit 0: reseed; bits 7:1: zero
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;  // bits 30:0: draw; bit 31: zero

  // Generator mirror used to predict every draw.
  logic [VAL_W-1:0] seed_reg;
  logic [VAL_W-1:0] gen_x;
  logic [VAL_W-1:0] prev_draw;
  logic [VAL_W-1:0] shuffle [TBL];

  logic [VAL_W-1:0] expected_draws [$];
  int outstanding = 0;
  int error_count = 0;
  int quiet_cycles = 0;
  int send_idle_pct = 0;
  int rcv_stall_pct = 0;
  dir_row_t directed_rows [NUM_DIRECTED];

  shuffled_lehmer_random_top #(
    .TABLE_ENTRIES(TBL)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // One minimal-standard step: x * 16807 mod (2^31 - 1).
  function automatic logic [VAL_W-1:0] lehmer_step(input logic [VAL_W-1:0] x);
    logic [63:0] prod;
    prod = 64'(x) * 64'(LEHMER_MULT);
    return VAL_W'(prod % 64'(LEHMER_MOD));
  endfunction

  // Reload from the seed, run the warm-up and fill the table from the top
  // down, so the last value computed lands in entry 0.
  function automatic void refill_shuffle();
    logic [VAL_W-1:0] x;
    x = seed_reg;
    if (x == '0 || x == LEHMER_MOD) x = SEED_ONE;
    for (int n = TBL + WARMUP_EXTRA - 1; n >= 0; n--) begin
      x = lehmer_step(x);
      if (n < TBL) shuffle[n] = x;
    end
    gen_x = x;
    prev_draw = shuffle[0];
  endfunction

  // Advance the generator and swap it into the slot picked by the last draw.
  function automatic logic [VAL_W-1:0] next_draw(input logic reseed_req);
    logic [63:0] slot;
    logic [VAL_W-1:0] picked;
    if (reseed_req || prev_draw == '0) refill_shuffle();
    gen_x = lehmer_step(gen_x);
    slot = (64'(prev_draw) * TBL) / (64'(LEHMER_MOD) - 64'd1 + TBL);
    if (slot >= TBL) slot = 64'(TBL - 1);
    picked = shuffle[slot];
    shuffle[slot] = gen_x;
    prev_draw = picked;
    return picked;
  endfunction

  // Scoreboard: check each output beat, then predict each input beat.
  always @(posedge clk) begin
    logic [VAL_W-1:0] want;
    if (rst) begin
      seed_reg = SEED_ONE;
      gen_x = '0;
      prev_draw = '0;
      outstanding <= 0;
    end else begin
      if (cfg_wr_en) seed_reg = cfg_wr_data;
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_draws.size() == 0) begin
          error_count++;
          $display("%0t: unexpected draw beat: expected none, actual %h", $time,
                   m_axis_tdata);
        end else begin
          want = expected_draws.pop_front();
          if (m_axis_tdata !== {1'b0, want}) begin
            error_count++;
            $display("%0t: draw mismatch: expected %h, actual %h", $time,
                     {1'b0, want}, m_axis_tdata);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) expected_draws.push_back(next_draw(s_axis_tdata[0]));
      outstanding <= expected_draws.size();
    end
  end

  // Output backpressure.
  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= rcv_stall_pct);
  end

  // Watchdog on cycles with no beat on either side.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("tb_shuffled_lehmer_random_top: done, errors");
      $finish;
    end
  end

  // Hold the input off until every pending draw has come out.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_seed(input logic [VAL_W-1:0] value);
    wait_idle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Present one input beat, with random idle cycles ahead of it.
  task automatic send_beat(input logic reseed);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {7'b0, reseed};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  function automatic logic [VAL_W-1:0] pick_seed();
    case ($urandom_range(5))
      0: return SEED_ZERO;
      1: return SEED_ONE;
      2: return SEED_MAX;
      3: return SEED_LOCK;
      default: return VAL_W'($urandom);
    endcase
  endfunction

  initial begin
    rst <= 1'b1;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;

    // Directed rows: {write seed, seed value, reseed}. No draw can be read off
    // by eye, so each row is checked against the prediction.
    directed_rows = '{
      '{1'b0, SEED_ZERO, 1'b0},        // first beat after reset seeds itself
      '{1'b0, SEED_ZERO, 1'b0},
      '{1'b0, SEED_ZERO, 1'b0},
      '{1'b0, SEED_ZERO, 1'b1},        // reseed with the reset seed
      '{1'b0, SEED_ZERO, 1'b1},        // back-to-back reseeds
      '{1'b1, SEED_MAX, 1'b1},         // top of the seed range
      '{1'b0, SEED_ZERO, 1'b0},
      '{1'b0, SEED_ZERO, 1'b0},
      '{1'b1, SEED_ZERO, 1'b1},        // zero seed is taken as one
      '{1'b0, SEED_ZERO, 1'b0},
      '{1'b1, SEED_LOCK, 1'b1},        // modulus as seed is taken as one
      '{1'b0, SEED_ZERO, 1'b0},
      '{1'b1, 31'd12345, 1'b0},        // a new seed alone does not restart
      '{1'b0, SEED_ZERO, 1'b0},
      '{1'b0, SEED_ZERO, 1'b1},
      '{1'b1, 31'h5555_5555, 1'b1},
      '{1'b1, 31'h2AAA_AAAA, 1'b1},
      '{1'b0, SEED_ZERO, 1'b0},
      '{1'b1, SEED_ONE, 1'b0},
      '{1'b0, SEED_ZERO, 1'b1}
    };

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int r = 0; r < NUM_DIRECTED; r++) begin
      if (directed_rows[r].wr_seed) write_seed(directed_rows[r].seed);
      send_beat(directed_rows[r].reseed);
    end

    // Random phases: no idling, idle sender, stalling receiver, then both.
    for (int ph = 0; ph < 4; ph++) begin
      write_seed(pick_seed());
      case (ph)
        0: begin send_idle_pct = 0; rcv_stall_pct <= 0; end
        1: begin send_idle_pct = 56; rcv_stall_pct <= 0; end
        2: begin send_idle_pct = 0; rcv_stall_pct <= 56; end
        default: begin send_idle_pct = 37; rcv_stall_pct <= 37; end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n % 160 == 159) write_seed(pick_seed());
        send_beat($urandom_range(11) == 0);
      end
    end

    // Drain, then let a full reseed time pass for stray beats to show up.
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (RESEED_CYCLES + 8) @(posedge clk);

    if (expected_draws.size() != 0) begin
      error_count++;
      $display("%0t: %0d expected draws never arrived", $time, expected_draws.size());
    end
    if (error_count == 0)
      $display("tb_shuffled_lehmer_random_top: done, clean");
    else
      $display("tb_shuffled_lehmer_random_top: done, errors");
    $finish;
  end

endmodule

### sim.f
rtl/slr_pkg.sv
rtl/slr_lehmer_unit.sv
rtl/shuffled_lehmer_random_top.sv
dv/tb_shuffled_lehmer_random_top.sv
